// ===== src/rpv_pkg.sv =====
`default_nettype none

package rpv_pkg;

  // Field widths of the request and response beats
  localparam int CMD_W     = 3;
  localparam int CLIENT_W  = 3;
  localparam int TMO_W     = 16;
  localparam int EVENT_W   = 32;

  // Default sizing of the slot pool
  localparam int SLOTS_DEF      = 8;
  localparam int TIMER_BITS_DEF = 16;

  // Command codes; the remaining codes do nothing
  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC = 3'd0,
    CMD_FREE  = 3'd1,
    CMD_ON    = 3'd2,
    CMD_OFF   = 3'd3,
    CMD_TICK  = 3'd4
  } cmd_t;

  // Controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_ALLOC,
    S_TICK,
    S_READ,
    S_EXEC,
    S_DONE
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;        // capture the request beat, clear pending result
    logic alloc_step;  // test one slot, take it or advance the scan
    logic tick_step;   // read next slot timer, update the one read before
    logic rd_client;   // address the memories with the client index
    logic exec;        // apply free, on, off, or finish tick and others
    logic out_load;    // move the pending result into the output register
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic alloc_hit;   // slot under the scan is free
    logic scan_last;   // scan sits on the last slot
    logic scan_end;    // scan has passed the last slot
    logic out_busy;    // output register holds a beat not yet taken
  } ctrl_stat_t;

endpackage

`default_nettype wire

// ===== src/rpv_if.sv =====
`default_nettype none

// Request channel
interface rpv_req_if;
  logic                         valid;
  logic                         ready;
  logic [rpv_pkg::CMD_W-1:0]    command;
  logic [rpv_pkg::CLIENT_W-1:0] client;
  logic [rpv_pkg::TMO_W-1:0]    timeout_ticks;

  modport source (output valid, command, client, timeout_ticks, input ready);
  modport sink (input valid, command, client, timeout_ticks, output ready);
endinterface

// Response channel
interface rpv_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [rpv_pkg::CLIENT_W-1:0] granted_slot;
  logic                         ok;
  logic                         radio_enable;
  logic                         mac_on_pulse;
  logic                         mac_off_pulse;
  logic [rpv_pkg::EVENT_W-1:0]  client_on_events;
  logic [rpv_pkg::EVENT_W-1:0]  client_off_events;

  modport source (output valid, granted_slot, ok, radio_enable, mac_on_pulse,
                  mac_off_pulse, client_on_events, client_off_events, input ready);
  modport sink (input valid, granted_slot, ok, radio_enable, mac_on_pulse,
                mac_off_pulse, client_on_events, client_off_events, output ready);
endinterface

`default_nettype wire

// ===== src/radio_power_vote_with_timeouts_core.sv =====
`default_nettype none

// Radio power vote: a pool of SLOTS client slots, each with a used mark, an
// on flag, a TIMER_BITS countdown and wrapping on/off event counters, votes
// for one shared radio. Each request beat gives exactly one response beat.
// Free, on, off and unknown codes pass through the states READ, EXEC and
// DONE; alloc scans the used marks one slot a cycle from slot 0 until it
// finds the lowest free slot or reaches the last one, then goes to DONE;
// tick reads the timer memory one slot a cycle and updates each slot in the
// cycle after its read, then passes through READ, EXEC and DONE. A new
// request is taken once the previous response sits in the output register,
// even if that beat has not yet been taken.
// After reset the block is ready at once; counters of never-allocated slots
// read as zero.
module radio_power_vote_with_timeouts_core #(
  parameter int SLOTS      = rpv_pkg::SLOTS_DEF,
  parameter int TIMER_BITS = rpv_pkg::TIMER_BITS_DEF
) (
  input wire logic clk,
  input wire logic rst,
  rpv_req_if.sink  req,
  rpv_rsp_if.source rsp
);

  rpv_pkg::ctrl_cmd_t  cmd;
  rpv_pkg::ctrl_stat_t stat;

  // Sequencer
  rpv_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (req.valid),
    .in_command (req.command),
    .stat       (stat),
    .in_ready   (req.ready),
    .cmd        (cmd)
  );

  // Slot state, memories and output register
  rpv_dp #(
    .SLOTS      (SLOTS),
    .TIMER_BITS (TIMER_BITS)
  ) u_dp (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .stat              (stat),
    .command           (req.command),
    .client            (req.client),
    .timeout_ticks     (req.timeout_ticks),
    .out_valid         (rsp.valid),
    .out_ready         (rsp.ready),
    .granted_slot      (rsp.granted_slot),
    .ok                (rsp.ok),
    .radio_enable      (rsp.radio_enable),
    .mac_on_pulse      (rsp.mac_on_pulse),
    .mac_off_pulse     (rsp.mac_off_pulse),
    .client_on_events  (rsp.client_on_events),
    .client_off_events (rsp.client_off_events)
  );

endmodule

`default_nettype wire

// ===== src/rpv_ctrl.sv =====
`default_nettype none

module rpv_ctrl (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  input  wire logic [rpv_pkg::CMD_W-1:0] in_command,
  input  wire rpv_pkg::ctrl_stat_t       stat,
  output logic                           in_ready,
  output rpv_pkg::ctrl_cmd_t             cmd
);

  rpv_pkg::state_t state;
  rpv_pkg::state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rpv_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    cmd        = '0;
    unique case (state)
      rpv_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          priority if (rpv_pkg::cmd_t'(in_command) == rpv_pkg::CMD_ALLOC) begin
            state_next = rpv_pkg::S_ALLOC;
          end else if (rpv_pkg::cmd_t'(in_command) == rpv_pkg::CMD_TICK) begin
            state_next = rpv_pkg::S_TICK;
          end else begin
            state_next = rpv_pkg::S_READ;
          end
        end
      end
      rpv_pkg::S_ALLOC: begin
        cmd.alloc_step = 1'b1;
        if (stat.alloc_hit || stat.scan_last) begin
          state_next = rpv_pkg::S_DONE;
        end
      end
      rpv_pkg::S_TICK: begin
        cmd.tick_step = 1'b1;
        if (stat.scan_end) begin
          state_next = rpv_pkg::S_READ;
        end
      end
      rpv_pkg::S_READ: begin
        cmd.rd_client = 1'b1;
        state_next    = rpv_pkg::S_EXEC;
      end
      rpv_pkg::S_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = rpv_pkg::S_DONE;
      end
      rpv_pkg::S_DONE: begin
        if (!stat.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = rpv_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = rpv_pkg::S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== src/rpv_dp.sv =====
`default_nettype none

module rpv_dp #(
  parameter int SLOTS      = rpv_pkg::SLOTS_DEF,
  parameter int TIMER_BITS = rpv_pkg::TIMER_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire rpv_pkg::ctrl_cmd_t           cmd,
  output rpv_pkg::ctrl_stat_t               stat,
  input  wire logic [rpv_pkg::CMD_W-1:0]    command,
  input  wire logic [rpv_pkg::CLIENT_W-1:0] client,
  input  wire logic [rpv_pkg::TMO_W-1:0]    timeout_ticks,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [rpv_pkg::CLIENT_W-1:0]      granted_slot,
  output logic                              ok,
  output logic                              radio_enable,
  output logic                              mac_on_pulse,
  output logic                              mac_off_pulse,
  output logic [rpv_pkg::EVENT_W-1:0]       client_on_events,
  output logic [rpv_pkg::EVENT_W-1:0]       client_off_events
);

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int SCN_W = IDX_W + 1;
  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam int EW    = rpv_pkg::EVENT_W;

  // Captured request
  rpv_pkg::cmd_t                 cmd_r;
  logic [rpv_pkg::CLIENT_W-1:0]  client_r;
  logic [TIMER_BITS-1:0]         tmo_r;

  // Slot flags; seen marks slots whose counters were ever written
  logic [SLOTS-1:0] used, used_next;
  logic [SLOTS-1:0] active, active_next;
  logic [SLOTS-1:0] seen, seen_next;
  logic [CNT_W-1:0] count, count_next;

  // Timer and event counter memories
  logic [TIMER_BITS-1:0] timer_mem [SLOTS];
  logic [EW-1:0]         on_mem    [SLOTS];
  logic [EW-1:0]         off_mem   [SLOTS];
  logic [TIMER_BITS-1:0] rd_timer;
  logic [EW-1:0]         rd_on;
  logic [EW-1:0]         rd_off;
  logic                  rd_seen;

  // Scan and tick update stage
  logic [SCN_W-1:0] scan, scan_next;
  logic             proc_v, proc_v_next;
  logic [IDX_W-1:0] proc_idx;

  // Pending result
  logic [rpv_pkg::CLIENT_W-1:0] pend_addr, pend_addr_next;
  logic                         pend_ok, pend_ok_next;
  logic                         pend_on_p, pend_on_p_next;
  logic                         pend_off_p, pend_off_p_next;
  logic [EW-1:0]                pend_on_cnt, pend_on_cnt_next;
  logic [EW-1:0]                pend_off_cnt, pend_off_cnt_next;

  // Memory write ports
  logic                  tw_en, ow_en, fw_en;
  logic [IDX_W-1:0]      tw_addr, ow_addr, fw_addr;
  logic [TIMER_BITS-1:0] tw_data;
  logic [EW-1:0]         ow_data, fw_data;

  logic [31:0]      client_ext;
  logic [31:0]      tmo_ext;
  logic [31:0]      scan_ext;
  logic [IDX_W-1:0] cl_idx;
  logic [IDX_W-1:0] scan_idx;
  logic [IDX_W-1:0] rd_addr;
  logic             in_pool;
  logic             usable;
  logic             act;
  logic             drop;
  logic             turn_on;
  logic [EW-1:0]    on_val;
  logic [EW-1:0]    off_val;

  assign client_ext = 32'(client_r);
  assign tmo_ext    = 32'(timeout_ticks);
  assign scan_ext   = 32'(scan);
  assign cl_idx     = client_ext[IDX_W-1:0];
  assign scan_idx   = scan[IDX_W-1:0];
  assign rd_addr    = cmd.rd_client ? cl_idx : scan_idx;
  assign in_pool    = client_ext < 32'(SLOTS);
  assign usable     = in_pool && used[cl_idx];
  assign act        = active[cl_idx];
  assign on_val     = rd_seen ? rd_on : '0;
  assign off_val    = rd_seen ? rd_off : '0;
  assign drop       = usable && act && ((cmd_r == rpv_pkg::CMD_FREE) ||
                                        (cmd_r == rpv_pkg::CMD_OFF));
  assign turn_on    = usable && !act && (cmd_r == rpv_pkg::CMD_ON);

  // Status to the controller
  assign stat.alloc_hit = !used[scan_idx];
  assign stat.scan_last = scan == SCN_W'(SLOTS - 1);
  assign stat.scan_end  = scan == SCN_W'(SLOTS);
  assign stat.out_busy  = out_valid && !out_ready;

  // Slot state updates for every command step
  always_comb begin
    used_next         = used;
    active_next       = active;
    seen_next         = seen;
    count_next        = count;
    scan_next         = scan;
    proc_v_next       = 1'b0;
    pend_addr_next    = pend_addr;
    pend_ok_next      = pend_ok;
    pend_on_p_next    = pend_on_p;
    pend_off_p_next   = pend_off_p;
    pend_on_cnt_next  = pend_on_cnt;
    pend_off_cnt_next = pend_off_cnt;
    tw_en   = 1'b0;
    tw_addr = cl_idx;
    tw_data = '0;
    ow_en   = 1'b0;
    ow_addr = cl_idx;
    ow_data = '0;
    fw_en   = 1'b0;
    fw_addr = cl_idx;
    fw_data = '0;

    // Start a new request with an empty result
    if (cmd.load) begin
      scan_next         = '0;
      pend_ok_next      = 1'b0;
      pend_on_p_next    = 1'b0;
      pend_off_p_next   = 1'b0;
      pend_on_cnt_next  = '0;
      pend_off_cnt_next = '0;
      pend_addr_next    = (rpv_pkg::cmd_t'(command) == rpv_pkg::CMD_ALLOC) ? '0 : client;
    end

    // Take the lowest free slot and clear its timer and counters
    if (cmd.alloc_step) begin
      if (!used[scan_idx]) begin
        used_next[scan_idx] = 1'b1;
        seen_next[scan_idx] = 1'b1;
        tw_en          = 1'b1;
        tw_addr        = scan_idx;
        ow_en          = 1'b1;
        ow_addr        = scan_idx;
        fw_en          = 1'b1;
        fw_addr        = scan_idx;
        pend_addr_next = scan_ext[rpv_pkg::CLIENT_W-1:0];
        pend_ok_next   = 1'b1;
      end else begin
        scan_next = scan + SCN_W'(1);
      end
    end

    // Advance the timer scan; expire or decrement the slot read last cycle
    if (cmd.tick_step) begin
      if (!stat.scan_end) begin
        scan_next = scan + SCN_W'(1);
      end
      proc_v_next = !stat.scan_end;
      if (proc_v && active[proc_idx]) begin
        tw_en   = 1'b1;
        tw_addr = proc_idx;
        if (rd_timer[TIMER_BITS-1:1] == '0) begin
          active_next[proc_idx] = 1'b0;
          tw_data    = '0;
          fw_en      = 1'b1;
          fw_addr    = proc_idx;
          fw_data    = off_val + EW'(1);
          count_next = count - CNT_W'(1);
          if (count == CNT_W'(1)) begin
            pend_off_p_next = 1'b1;
          end
        end else begin
          tw_data = rd_timer - TIMER_BITS'(1);
        end
      end
    end

    // Apply the addressed command and report the slot counters
    if (cmd.exec) begin
      unique case (cmd_r)
        rpv_pkg::CMD_FREE: begin
          pend_ok_next = usable;
          if (usable) begin
            used_next[cl_idx] = 1'b0;
          end
        end
        rpv_pkg::CMD_ON: begin
          pend_ok_next = usable;
          if (usable) begin
            tw_en   = 1'b1;
            tw_data = tmo_r;
          end
        end
        rpv_pkg::CMD_OFF: begin
          pend_ok_next = usable;
        end
        rpv_pkg::CMD_TICK: begin
          pend_ok_next = 1'b1;
        end
        default: begin
          pend_ok_next = 1'b0;
        end
      endcase
      if (drop) begin
        active_next[cl_idx] = 1'b0;
        tw_en      = 1'b1;
        tw_data    = '0;
        fw_en      = 1'b1;
        fw_data    = off_val + EW'(1);
        count_next = count - CNT_W'(1);
        pend_off_p_next = count == CNT_W'(1);
      end
      if (turn_on) begin
        active_next[cl_idx] = 1'b1;
        ow_en      = 1'b1;
        ow_data    = on_val + EW'(1);
        count_next = count + CNT_W'(1);
        pend_on_p_next = count == '0;
      end
      pend_on_cnt_next  = in_pool ? on_val + EW'(turn_on) : '0;
      pend_off_cnt_next = in_pool ? off_val + EW'(drop) : '0;
    end
  end

  // Control flags
  always_ff @(posedge clk) begin
    if (rst) begin
      used      <= '0;
      active    <= '0;
      seen      <= '0;
      count     <= '0;
      proc_v    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      used   <= used_next;
      active <= active_next;
      seen   <= seen_next;
      count  <= count_next;
      proc_v <= proc_v_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Request capture, scan and pending result
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r    <= rpv_pkg::cmd_t'(command);
      client_r <= client;
      tmo_r    <= tmo_ext[TIMER_BITS-1:0];
    end
    scan         <= scan_next;
    proc_idx     <= scan_idx;
    pend_addr    <= pend_addr_next;
    pend_ok      <= pend_ok_next;
    pend_on_p    <= pend_on_p_next;
    pend_off_p   <= pend_off_p_next;
    pend_on_cnt  <= pend_on_cnt_next;
    pend_off_cnt <= pend_off_cnt_next;
  end

  // Memories: one write and one registered read each
  always_ff @(posedge clk) begin
    if (tw_en) begin
      timer_mem[tw_addr] <= tw_data;
    end
    if (ow_en) begin
      on_mem[ow_addr] <= ow_data;
    end
    if (fw_en) begin
      off_mem[fw_addr] <= fw_data;
    end
    rd_timer <= timer_mem[rd_addr];
    rd_on    <= on_mem[rd_addr];
    rd_off   <= off_mem[rd_addr];
    rd_seen  <= seen[rd_addr];
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      granted_slot      <= pend_addr;
      ok                <= pend_ok;
      radio_enable      <= count != '0;
      mac_on_pulse      <= pend_on_p;
      mac_off_pulse     <= pend_off_p;
      client_on_events  <= pend_on_cnt;
      client_off_events <= pend_off_cnt;
    end
  end

endmodule

`default_nettype wire

// ===== src/rpv_chk.sv =====
`default_nettype none

module rpv_chk (
  input wire logic                         clk,
  input wire logic                         rst,
  input wire logic                         out_valid,
  input wire logic                         out_ready,
  input wire logic [rpv_pkg::CLIENT_W-1:0] granted_slot,
  input wire logic                         ok,
  input wire logic                         radio_enable,
  input wire logic                         mac_on_pulse,
  input wire logic                         mac_off_pulse,
  input wire logic [rpv_pkg::EVENT_W-1:0]  client_on_events,
  input wire logic [rpv_pkg::EVENT_W-1:0]  client_off_events
);

  // Hold a stalled response beat
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(granted_slot) && $stable(ok)
      && $stable(radio_enable) && $stable(client_on_events)
      && $stable(client_off_events))
    else $error("response beat changed while stalled");

  // An on pulse leaves the radio enabled
  a_on_enable: assert property (@(posedge clk) disable iff (rst)
    out_valid && mac_on_pulse |-> radio_enable && ok)
    else $error("mac on pulse without radio enable");

  // An off pulse leaves the radio disabled
  a_off_disable: assert property (@(posedge clk) disable iff (rst)
    out_valid && mac_off_pulse |-> !radio_enable)
    else $error("mac off pulse with radio enabled");

  // One command never raises both pulses
  a_pulse_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(mac_on_pulse && mac_off_pulse))
    else $error("both mac pulses in one beat");

endmodule

bind radio_power_vote_with_timeouts_core rpv_chk u_rpv_chk (
  .clk               (clk),
  .rst               (rst),
  .out_valid         (rsp.valid),
  .out_ready         (rsp.ready),
  .granted_slot      (rsp.granted_slot),
  .ok                (rsp.ok),
  .radio_enable      (rsp.radio_enable),
  .mac_on_pulse      (rsp.mac_on_pulse),
  .mac_off_pulse     (rsp.mac_off_pulse),
  .client_on_events  (rsp.client_on_events),
  .client_off_events (rsp.client_off_events)
);

`default_nettype wire

// ===== verif/rpv_vote_checker.sv =====
`default_nettype none

// Watch the request and response channels of the radio power vote, predict
// each response from the accepted requests and compare field by field.
module rpv_vote_checker #(
  parameter int SLOTS = rpv_pkg::SLOTS_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  rpv_req_if        req,
  rpv_rsp_if        rsp,
  output int        fail_count,
  output int        outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [rpv_pkg::CLIENT_W-1:0] granted_slot;
    logic                         ok;
    logic                         radio_enable;
    logic                         mac_on_pulse;
    logic                         mac_off_pulse;
    logic [rpv_pkg::EVENT_W-1:0]  client_on_events;
    logic [rpv_pkg::EVENT_W-1:0]  client_off_events;
  } vote_result_t;

  // Shadow of the slot pool
  bit                          slot_taken [SLOTS];
  bit                          slot_on    [SLOTS];
  logic [rpv_pkg::TMO_W-1:0]   slot_timer [SLOTS];
  logic [rpv_pkg::EVENT_W-1:0] on_tally   [SLOTS];
  logic [rpv_pkg::EVENT_W-1:0] off_tally  [SLOTS];
  int unsigned                 on_clients;

  vote_result_t vote_q[$];
  vote_result_t want;

  // Turn one client off; report whether the radio lost its last vote
  function automatic bit drop_vote(int s);
    slot_on[s]    = 1'b0;
    slot_timer[s] = '0;
    off_tally[s]  = off_tally[s] + rpv_pkg::EVENT_W'(1);
    if (on_clients > 0) on_clients--;
    return on_clients == 0;
  endfunction

  function automatic vote_result_t predict_vote(logic [rpv_pkg::CMD_W-1:0] code,
                                                logic [rpv_pkg::CLIENT_W-1:0] cl,
                                                logic [rpv_pkg::TMO_W-1:0] tmo);
    vote_result_t r;
    int  addr;
    bit  addr_ok;
    bit  usable;
    r       = '0;
    addr    = int'(cl);
    addr_ok = (cl < SLOTS);
    usable  = addr_ok && slot_taken[cl];
    unique case (code)
      rpv_pkg::CMD_ALLOC: begin
        addr    = 0;
        addr_ok = 1'b0;
        for (int i = 0; i < SLOTS; i++) begin
          if (!addr_ok && !slot_taken[i]) begin
            slot_taken[i] = 1'b1;
            slot_on[i]    = 1'b0;
            slot_timer[i] = '0;
            on_tally[i]   = '0;
            off_tally[i]  = '0;
            addr          = i;
            addr_ok       = 1'b1;
            r.ok          = 1'b1;
          end
        end
      end
      rpv_pkg::CMD_FREE: begin
        if (usable) begin
          if (slot_on[cl]) r.mac_off_pulse = drop_vote(int'(cl));
          slot_taken[cl] = 1'b0;
          r.ok = 1'b1;
        end
      end
      rpv_pkg::CMD_ON: begin
        if (usable) begin
          if (!slot_on[cl]) begin
            slot_on[cl]  = 1'b1;
            on_tally[cl] = on_tally[cl] + rpv_pkg::EVENT_W'(1);
            on_clients++;
            r.mac_on_pulse = (on_clients == 1);
          end
          slot_timer[cl] = tmo;
          r.ok = 1'b1;
        end
      end
      rpv_pkg::CMD_OFF: begin
        if (usable) begin
          if (slot_on[cl]) r.mac_off_pulse = drop_vote(int'(cl));
          r.ok = 1'b1;
        end
      end
      rpv_pkg::CMD_TICK: begin
        // expire timers at zero or one, count the rest down
        for (int i = 0; i < SLOTS; i++) begin
          if (slot_on[i]) begin
            if (slot_timer[i] <= rpv_pkg::TMO_W'(1)) begin
              if (drop_vote(i)) r.mac_off_pulse = 1'b1;
            end else begin
              slot_timer[i] = slot_timer[i] - rpv_pkg::TMO_W'(1);
            end
          end
        end
        r.ok = 1'b1;
      end
      default: ;
    endcase
    r.granted_slot = addr[rpv_pkg::CLIENT_W-1:0];
    r.radio_enable = (on_clients != 0);
    if (addr_ok && addr < SLOTS) begin
      r.client_on_events  = on_tally[addr];
      r.client_off_events = off_tally[addr];
    end
    return r;
  endfunction

  function automatic void check_field(string name, logic [rpv_pkg::EVENT_W-1:0] exp_v,
                                      logic [rpv_pkg::EVENT_W-1:0] act_v);
    if (act_v !== exp_v) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, act_v);
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) begin
        slot_taken[i] = 1'b0;
        slot_on[i]    = 1'b0;
        slot_timer[i] = '0;
        on_tally[i]   = '0;
        off_tally[i]  = '0;
      end
      on_clients = 0;
      fail_count = 0;
      vote_q.delete();
      outstanding <= 0;
    end else begin
      // predict on every accepted request beat
      if (req.valid && req.ready)
        vote_q.push_back(predict_vote(req.command, req.client, req.timeout_ticks));
      // compare every accepted response beat with the oldest prediction
      if (rsp.valid && rsp.ready) begin
        if (vote_q.size() == 0) begin
          fail_count++;
          $display("%0t: response beat with nothing expected, got slot %0d ok %0b",
                   $time, rsp.granted_slot, rsp.ok);
        end else begin
          want = vote_q.pop_front();
          check_field("granted_slot", rpv_pkg::EVENT_W'(want.granted_slot),
                      rpv_pkg::EVENT_W'(rsp.granted_slot));
          check_field("ok", rpv_pkg::EVENT_W'(want.ok), rpv_pkg::EVENT_W'(rsp.ok));
          check_field("radio_enable", rpv_pkg::EVENT_W'(want.radio_enable),
                      rpv_pkg::EVENT_W'(rsp.radio_enable));
          check_field("mac_on_pulse", rpv_pkg::EVENT_W'(want.mac_on_pulse),
                      rpv_pkg::EVENT_W'(rsp.mac_on_pulse));
          check_field("mac_off_pulse", rpv_pkg::EVENT_W'(want.mac_off_pulse),
                      rpv_pkg::EVENT_W'(rsp.mac_off_pulse));
          check_field("client_on_events", want.client_on_events, rsp.client_on_events);
          check_field("client_off_events", want.client_off_events,
                      rsp.client_off_events);
        end
      end
      outstanding <= vote_q.size();
    end
  end

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS      = rpv_pkg::SLOTS_DEF;
  localparam int CODE_TOP   = (1 << rpv_pkg::CMD_W) - 1;
  localparam int TMO_TOP    = (1 << rpv_pkg::TMO_W) - 1;
  localparam int DRAIN_CYC  = SLOTS + 12;
  localparam int RAND_ITEMS = 1350;

  logic clk;
  logic rst;
  int   fail_count;
  int   outstanding;
  int   idle_pct;
  int   stall_pct;
  bit   used_mirror [SLOTS];

  rpv_req_if req_ch ();
  rpv_rsp_if rsp_ch ();

  radio_power_vote_with_timeouts_core dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  rpv_vote_checker #(.SLOTS(SLOTS)) vote_chk (
    .clk         (clk),
    .rst         (rst),
    .req         (req_ch),
    .rsp         (rsp_ch),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Stall the response side at random
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Hold the request until the block takes it, idling at random before it
  task automatic send_cmd(input logic [rpv_pkg::CMD_W-1:0] code,
                          input logic [rpv_pkg::CLIENT_W-1:0] cl,
                          input logic [rpv_pkg::TMO_W-1:0] tmo);
    int gap;
    gap = 0;
    while ($urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid         <= 1'b1;
    req_ch.command       <= code;
    req_ch.client        <= cl;
    req_ch.timeout_ticks <= tmo;
    do @(posedge clk); while (!req_ch.ready);
    // track which slots are in use so random commands mostly hit live ones
    if (code == rpv_pkg::CMD_ALLOC) begin
      for (int i = 0; i < SLOTS; i++) begin
        if (!used_mirror[i]) begin
          used_mirror[i] = 1'b1;
          break;
        end
      end
    end else if (code == rpv_pkg::CMD_FREE && cl < SLOTS) begin
      used_mirror[cl] = 1'b0;
    end
  endtask

  // Drop valid and wait until every response beat has come back
  task automatic drain_results();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  function automatic logic [rpv_pkg::CLIENT_W-1:0] pick_client();
    logic [rpv_pkg::CLIENT_W-1:0] c;
    bit any_used;
    any_used = 1'b0;
    for (int i = 0; i < SLOTS; i++) any_used |= used_mirror[i];
    c = rpv_pkg::CLIENT_W'($urandom_range((1 << rpv_pkg::CLIENT_W) - 1));
    if (any_used && $urandom_range(99) < 85) begin
      while (!(c < SLOTS && used_mirror[c]))
        c = rpv_pkg::CLIENT_W'($urandom_range(SLOTS - 1));
    end
    return c;
  endfunction

  function automatic logic [rpv_pkg::TMO_W-1:0] pick_timeout();
    int r;
    r = $urandom_range(99);
    if (r < 60) return rpv_pkg::TMO_W'($urandom_range(4));
    if (r < 85) return rpv_pkg::TMO_W'($urandom_range(40, 5));
    if (r < 95) return rpv_pkg::TMO_W'($urandom());
    return (r < 98) ? rpv_pkg::TMO_W'(TMO_TOP) : '0;
  endfunction

  task automatic send_random();
    int r;
    r = $urandom_range(99);
    if (r < 13)      send_cmd(rpv_pkg::CMD_ALLOC, rpv_pkg::CLIENT_W'($urandom()),
                              rpv_pkg::TMO_W'($urandom()));
    else if (r < 25) send_cmd(rpv_pkg::CMD_FREE, pick_client(),
                              rpv_pkg::TMO_W'($urandom()));
    else if (r < 55) send_cmd(rpv_pkg::CMD_ON, pick_client(), pick_timeout());
    else if (r < 68) send_cmd(rpv_pkg::CMD_OFF, pick_client(),
                              rpv_pkg::TMO_W'($urandom()));
    else if (r < 95) send_cmd(rpv_pkg::CMD_TICK, rpv_pkg::CLIENT_W'($urandom()),
                              rpv_pkg::TMO_W'($urandom()));
    else             send_cmd(rpv_pkg::CMD_W'($urandom_range(CODE_TOP,
                                                             rpv_pkg::CMD_TICK + 1)),
                              rpv_pkg::CLIENT_W'($urandom()),
                              rpv_pkg::TMO_W'($urandom()));
  endtask

  initial begin
    rst                  <= 1'b1;
    req_ch.valid         <= 1'b0;
    req_ch.command       <= rpv_pkg::CMD_TICK;
    req_ch.client        <= '0;
    req_ch.timeout_ticks <= '0;
    idle_pct  = 0;
    stall_pct = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed: unknown codes, commands to unused slots, empty tick
    send_cmd(rpv_pkg::CMD_W'(rpv_pkg::CMD_TICK + 1), '0, '0);
    send_cmd(rpv_pkg::CMD_W'(CODE_TOP), rpv_pkg::CLIENT_W'(SLOTS - 1),
             rpv_pkg::TMO_W'(TMO_TOP));
    send_cmd(rpv_pkg::CMD_ON, 3'd2, 16'd5);
    send_cmd(rpv_pkg::CMD_OFF, rpv_pkg::CLIENT_W'(SLOTS - 1), '0);
    send_cmd(rpv_pkg::CMD_FREE, '0, '0);
    send_cmd(rpv_pkg::CMD_TICK, '0, '0);
    // fill the pool, then one alloc too many
    repeat (SLOTS + 1) send_cmd(rpv_pkg::CMD_ALLOC, '0, '0);
    // zero timeout expires on the next tick, full timeout stays
    send_cmd(rpv_pkg::CMD_ON, '0, '0);
    send_cmd(rpv_pkg::CMD_ON, 3'd1, rpv_pkg::TMO_W'(TMO_TOP));
    send_cmd(rpv_pkg::CMD_TICK, '0, '0);
    // re-on of an active client reloads its timer only
    send_cmd(rpv_pkg::CMD_ON, '0, 16'd1);
    send_cmd(rpv_pkg::CMD_ON, '0, 16'd2);
    send_cmd(rpv_pkg::CMD_OFF, 3'd1, '0);
    send_cmd(rpv_pkg::CMD_TICK, '0, '0);
    send_cmd(rpv_pkg::CMD_TICK, '0, '0);
    // free an active client, free twice, then reuse the slot
    send_cmd(rpv_pkg::CMD_ON, rpv_pkg::CLIENT_W'(SLOTS - 1), 16'd9);
    send_cmd(rpv_pkg::CMD_FREE, rpv_pkg::CLIENT_W'(SLOTS - 1), '0);
    send_cmd(rpv_pkg::CMD_FREE, rpv_pkg::CLIENT_W'(SLOTS - 1), '0);
    send_cmd(rpv_pkg::CMD_ALLOC, '0, '0);
    drain_results();

    // random phases: no idling, sender idle, receiver stall, both
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct  = (ph == 1) ? 65 : (ph == 3) ? 18 : 0;
      stall_pct = (ph == 2) ? 65 : (ph == 3) ? 18 : 0;
      for (int n = 0; n < RAND_ITEMS / 4; n++) begin
        send_random();
        if (n == RAND_ITEMS / 8) drain_results();
      end
      drain_results();
    end

    req_ch.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (DRAIN_CYC) @(posedge clk);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Bound the run well beyond the slowest legal completion
  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

`default_nettype wire
